/* rtl/core/fea_pkg.sv */
`timescale 1ns / 1ps

package fea_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int STEP_W     = 5;
	localparam int CODE_W     = 15;
	localparam int ENERGY_W   = 28;
	localparam int TOTAL_W    = 32;
	localparam int FRAMES_W   = 17;
	localparam int STREAK_W   = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int LEVEL_W    = 20;
	localparam int FACTOR_W   = 8;
	localparam int PERIOD_W   = 16;
	localparam int CHAN_W     = 4;
	localparam int DIV_W      = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic signed [STEP_W-1:0] STEP_MAX = 5'sd13;
	localparam logic signed [STEP_W-1:0] STEP_MIN = -5'sd13;
	localparam logic [CODE_W-1:0] UNITY_CODE = 15'd4096;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET  = 3'd0,
		REG_LOW     = 3'd1,
		REG_MARGIN  = 3'd2,
		REG_FACTOR  = 3'd3,
		REG_PERIOD  = 3'd4,
		REG_CHANNEL = 3'd5
	} cfg_reg_t;

	// One queued word: the sample and its frame end flag.
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} fea_word_t;

	// Head of the queue as the back end sees it.
	typedef struct packed {
		logic      valid;
		fea_word_t word;
	} fea_head_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	function automatic logic [CODE_W-1:0] boost_code(input logic [3:0] m);
		logic [CODE_W-1:0] c;
		case (m)
			4'd1:    c = 15'd5120;
			4'd2:    c = 15'd6144;
			4'd3:    c = 15'd7168;
			4'd4:    c = 15'd8192;
			4'd5:    c = 15'd9216;
			4'd6:    c = 15'd10240;
			4'd7:    c = 15'd11264;
			4'd8:    c = 15'd12288;
			4'd9:    c = 15'd13312;
			4'd10:   c = 15'd14336;
			4'd11:   c = 15'd15360;
			4'd12:   c = 15'd16384;
			4'd13:   c = 15'd18432;
			default: c = UNITY_CODE;
		endcase
		return c;
	endfunction

	function automatic logic [CODE_W-1:0] cut_code(input logic [3:0] m);
		logic [CODE_W-1:0] c;
		case (m)
			4'd1:    c = 15'd3756;
			4'd2:    c = 15'd3416;
			4'd3:    c = 15'd3076;
			4'd4:    c = 15'd2736;
			4'd5:    c = 15'd2396;
			4'd6:    c = 15'd2056;
			4'd7:    c = 15'd1716;
			4'd8:    c = 15'd1376;
			4'd9:    c = 15'd1036;
			4'd10:   c = 15'd356;
			4'd11:   c = 15'd70;
			4'd12:   c = 15'd16;
			4'd13:   c = 15'd0;
			default: c = UNITY_CODE;
		endcase
		return c;
	endfunction

	// Gain code in Q3.12 for a volume step; step zero is unity.
	function automatic logic [CODE_W-1:0] gain_code(input logic [STEP_W-1:0] step);
		logic [STEP_W-1:0] mag;
		logic [CODE_W-1:0] c;
		mag = step[STEP_W-1] ? (STEP_W'(0) - step) : step;
		if (step[STEP_W-1]) begin
			c = cut_code(mag[3:0]);
		end else begin
			c = boost_code(mag[3:0]);
		end
		return c;
	endfunction

	function automatic logic [STREAK_W-1:0] sat_inc(input logic [STREAK_W-1:0] v);
		return (v == '1) ? v : v + STREAK_W'(1);
	endfunction

endpackage

/* rtl/core/fea_div.sv */
`timescale 1ns / 1ps

module fea_div (
	input  logic               clk,
	input  logic               arst_n,
	input  fea_pkg::div_req_t  req,
	output fea_pkg::div_rsp_t  rsp
);

	localparam int W     = fea_pkg::DIV_W;
	localparam int CNT_W = $clog2(W);

	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [W:0] shifted;
	logic [W:0] diff;

	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One quotient bit per cycle, restoring.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

/* rtl/core/fea_front.sv */
`timescale 1ns / 1ps

module fea_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [fea_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                                frame_end,
	output fea_pkg::fea_head_t                  head,
	input  logic                                pop
);

	localparam int DEPTH = fea_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	fea_pkg::fea_word_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic push;
	logic take;

	assign in_stall = (count_q == CNT_W'(DEPTH));
	assign push     = in_valid && !in_stall;
	assign take     = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (take) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, take})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q].sample <= sample_in;
			slot_q[wr_ptr_q].last   <= frame_end;
		end
	end

	assign head.valid = (count_q != '0);
	assign head.word  = slot_q[rd_ptr_q];

endmodule

/* rtl/core/fea_back.sv */
`timescale 1ns / 1ps

module fea_back #(
	parameter int MAX_FRAME_ITEMS = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [fea_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [fea_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  fea_pkg::fea_head_t                    head,
	output logic                                  pop,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [fea_pkg::SAMPLE_W-1:0]   sample_out,
	output logic                                  frame_last,
	output logic                                  period_done,
	output logic signed [fea_pkg::STEP_W-1:0]     volume_step
);

	localparam int ITEM_W = $clog2(MAX_FRAME_ITEMS + 1);
	localparam int SW     = fea_pkg::SAMPLE_W;
	localparam int DW     = fea_pkg::DIV_W;
	localparam int EW     = fea_pkg::ENERGY_W;
	localparam int TW     = fea_pkg::TOTAL_W;
	localparam int FW     = fea_pkg::FRAMES_W;
	localparam int KW     = fea_pkg::STREAK_W;
	localparam int PW     = 20;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_SAMP,
		ST_ENRG,
		ST_SCORE,
		ST_AVG,
		ST_STREAK,
		ST_STEP
	} state_t;

	state_t state_q;

	logic [fea_pkg::LEVEL_W-1:0]  target_q;
	logic [fea_pkg::LEVEL_W-1:0]  low_q;
	logic [fea_pkg::LEVEL_W-1:0]  margin_q;
	logic [fea_pkg::FACTOR_W-1:0] factor_q;
	logic [fea_pkg::PERIOD_W-1:0] period_q;
	logic [fea_pkg::CHAN_W-1:0]   chan_q;

	logic [fea_pkg::STEP_W-1:0] gain_q;
	logic [EW-1:0]              energy_q;
	logic [ITEM_W-1:0]          items_q;
	logic [TW-1:0]              total_q;
	logic [FW-1:0]              frames_q;
	logic [KW-1:0]              over_q;
	logic [KW-1:0]              under_q;

	logic [PW-1:0]  prod_s1;
	logic           neg_s1;
	logic           last_s1;
	logic [SW-1:0]  y_q;
	logic [TW-1:0]  score_q;
	logic [DW-1:0]  avg_q;

	logic            out_valid_q;
	logic [SW-1:0]   sample_q;
	logic            last_q;
	logic            done_q;
	logic [fea_pkg::STEP_W-1:0] step_q;

	fea_pkg::div_req_t div_req_q;
	fea_pkg::div_rsp_t div_rsp;

	fea_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	// Channel count zero counts as one.
	logic [fea_pkg::CHAN_W-1:0] chan_eff;
	assign chan_eff = (chan_q == '0) ? fea_pkg::CHAN_W'(1) : chan_q;

	// Gain multiply on the queue head.
	logic [SW:0]   in_mag;
	logic [31:0]   product;
	assign in_mag  = head.word.sample[SW-1] ? ((SW+1)'(0) - {1'b1, head.word.sample})
	                                       : {1'b0, head.word.sample};
	assign product = 32'(in_mag) * 32'(fea_pkg::gain_code(gain_q));

	assign pop = (state_q == ST_IDLE) && head.valid && (!out_valid_q || !out_stall);

	// Saturate and accumulate.
	logic [SW-1:0]     y_mag;
	logic [SW-1:0]     y_val;
	logic [EW:0]       energy_sum;
	logic [EW-1:0]     energy_new;
	logic [ITEM_W-1:0] items_new;
	always_comb begin
		if (neg_s1) begin
			y_mag = (prod_s1 > PW'(32768)) ? SW'(32768) : prod_s1[SW-1:0];
			y_val = SW'(0) - y_mag;
		end else begin
			y_mag = (prod_s1 > PW'(32767)) ? SW'(32767) : prod_s1[SW-1:0];
			y_val = y_mag;
		end
		energy_sum = {1'b0, energy_q} + (EW+1)'(y_mag);
		energy_new = energy_sum[EW] ? '1 : energy_sum[EW-1:0];
		items_new  = (items_q < ITEM_W'(MAX_FRAME_ITEMS)) ? items_q + ITEM_W'(1) : items_q;
	end

	// Period bookkeeping.
	logic [TW:0]   total_sum;
	logic [TW-1:0] total_new;
	logic [FW-1:0] frames_new;
	logic          closes;
	assign total_sum  = {1'b0, total_q} + {1'b0, score_q};
	assign total_new  = total_sum[TW] ? '1 : total_sum[TW-1:0];
	assign frames_new = frames_q + FW'(1);
	assign closes     = frames_new > FW'(period_q);

	// Streak rules on the period average.
	logic [DW-1:0] target_w;
	logic [DW-1:0] margin_w;
	logic [KW-1:0] over_next;
	logic [KW-1:0] under_next;
	always_comb begin
		target_w = DW'(target_q);
		margin_w = DW'(margin_q);
		if (avg_q > target_w) begin
			over_next = ((avg_q - target_w) > margin_w) ? fea_pkg::sat_inc(over_q) : over_q;
		end else begin
			over_next = '0;
		end
		if (avg_q < DW'(low_q)) begin
			under_next = KW'(factor_q) + KW'(1);
		end else if ((avg_q < target_w) && ((target_w - avg_q) > margin_w)) begin
			under_next = fea_pkg::sat_inc(under_q);
		end else begin
			under_next = '0;
		end
	end

	logic [fea_pkg::STEP_W-1:0] gain_next;
	always_comb begin
		gain_next = gain_q;
		if (over_q > KW'(factor_q)) begin
			if ($signed(gain_q) > fea_pkg::STEP_MIN) begin
				gain_next = gain_q - fea_pkg::STEP_W'(1);
			end
		end else if (under_q > KW'(factor_q)) begin
			if ($signed(gain_q) < fea_pkg::STEP_MAX) begin
				gain_next = gain_q + fea_pkg::STEP_W'(1);
			end
		end
	end

	logic [DW-1:0] samples;
	assign samples = (div_rsp.quotient == '0) ? DW'(1) : div_rsp.quotient;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			low_q    <= '0;
			margin_q <= '0;
			factor_q <= '0;
			period_q <= '0;
			chan_q   <= fea_pkg::CHAN_W'(1);
		end else if (cfg_we) begin
			case (fea_pkg::cfg_reg_t'(cfg_index))
				fea_pkg::REG_TARGET:  target_q <= cfg_wdata[fea_pkg::LEVEL_W-1:0];
				fea_pkg::REG_LOW:     low_q    <= cfg_wdata[fea_pkg::LEVEL_W-1:0];
				fea_pkg::REG_MARGIN:  margin_q <= cfg_wdata[fea_pkg::LEVEL_W-1:0];
				fea_pkg::REG_FACTOR:  factor_q <= cfg_wdata[fea_pkg::FACTOR_W-1:0];
				fea_pkg::REG_PERIOD:  period_q <= cfg_wdata[fea_pkg::PERIOD_W-1:0];
				fea_pkg::REG_CHANNEL: chan_q   <= cfg_wdata[fea_pkg::CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			gain_q          <= '0;
			energy_q        <= '0;
			items_q         <= '0;
			total_q         <= '0;
			frames_q        <= '0;
			over_q          <= '0;
			under_q         <= '0;
			out_valid_q     <= 1'b0;
			div_req_q       <= '0;
			y_q             <= '0;
			score_q         <= '0;
			avg_q           <= '0;
			sample_q        <= '0;
			last_q          <= 1'b0;
			done_q          <= 1'b0;
			step_q          <= '0;
		end else begin
			div_req_q.start <= 1'b0;
			if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					y_q <= y_val;
					if (last_s1 && (target_q != '0)) begin
						energy_q           <= energy_new;
						div_req_q.start    <= 1'b1;
						div_req_q.dividend <= DW'(items_new);
						div_req_q.divisor  <= DW'(chan_eff);
						state_q            <= ST_SAMP;
					end else begin
						energy_q    <= last_s1 ? '0 : energy_new;
						items_q     <= last_s1 ? '0 : items_new;
						out_valid_q <= 1'b1;
						sample_q    <= y_val;
						last_q      <= last_s1;
						done_q      <= 1'b0;
						step_q      <= gain_q;
						state_q     <= ST_IDLE;
					end
				end
				ST_SAMP: begin
					if (div_rsp.done) begin
						div_req_q.start    <= 1'b1;
						div_req_q.dividend <= DW'(energy_q);
						div_req_q.divisor  <= samples;
						state_q            <= ST_ENRG;
					end
				end
				ST_ENRG: begin
					if (div_rsp.done) begin
						score_q <= TW'(div_rsp.quotient * DW'(chan_eff));
						state_q <= ST_SCORE;
					end
				end
				ST_SCORE: begin
					energy_q <= '0;
					items_q  <= '0;
					if (closes) begin
						total_q            <= '0;
						frames_q           <= '0;
						div_req_q.start    <= 1'b1;
						div_req_q.dividend <= DW'(total_new);
						div_req_q.divisor  <= DW'(frames_new);
						state_q            <= ST_AVG;
					end else begin
						total_q     <= total_new;
						frames_q    <= frames_new;
						out_valid_q <= 1'b1;
						sample_q    <= y_q;
						last_q      <= 1'b1;
						done_q      <= 1'b0;
						step_q      <= gain_q;
						state_q     <= ST_IDLE;
					end
				end
				ST_AVG: begin
					if (div_rsp.done) begin
						avg_q   <= div_rsp.quotient;
						state_q <= ST_STREAK;
					end
				end
				ST_STREAK: begin
					over_q  <= over_next;
					under_q <= under_next;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					gain_q      <= gain_next;
					out_valid_q <= 1'b1;
					sample_q    <= y_q;
					last_q      <= 1'b1;
					done_q      <= 1'b1;
					step_q      <= gain_next;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Product stage: capture the scaled magnitude as the word leaves the queue.
	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1 <= product[31:12];
			neg_s1  <= head.word.sample[SW-1];
			last_s1 <= head.word.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign sample_out  = sample_q;
	assign frame_last  = last_q;
	assign period_done = done_q;
	assign volume_step = step_q;

endmodule

/* rtl/core/frame_energy_agc.sv */
`timescale 1ns / 1ps
// Path: a word passes the queue slot, the product stage and the output register
// when the back end is free; a frame end with adaptation on (nonzero target) adds
// two divisions (items per channel, then energy per sample), and one that closes a
// period a third. Flow: the back end pops no new sample until it has finished the last.
// Reset: arst_n clears the queue, the gain loop and the output word at once;
// all config registers read zero except channel count, which reads 1.
module frame_energy_agc #(
	parameter int MAX_FRAME_ITEMS = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [fea_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [fea_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [fea_pkg::SAMPLE_W-1:0]   sample_in,
	input  logic                                  frame_end,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [fea_pkg::SAMPLE_W-1:0]   sample_out,
	output logic                                  frame_last,
	output logic                                  period_done,
	output logic signed [fea_pkg::STEP_W-1:0]     volume_step
);

	// The front end is a two-word queue: it takes words while the back end
	// is busy scaling or working through a frame-end division, and stalls the
	// source only when both slots are full.
	fea_pkg::fea_head_t head;
	logic               pop;

	fea_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_in (sample_in),
		.frame_end (frame_end),
		.head      (head),
		.pop       (pop)
	);

	// The back end pops one word at a time: multiply by the current gain code,
	// saturate, accumulate frame energy, and at a frame end with a nonzero target
	// run the score divisions, and at a period close the average division, on the
	// shared divider before moving the volume step. Its output register frees as
	// soon as the sink takes the word, so the next pop overlaps the handoff.
	fea_back #(
		.MAX_FRAME_ITEMS (MAX_FRAME_ITEMS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sample_out  (sample_out),
		.frame_last  (frame_last),
		.period_done (period_done),
		.volume_step (volume_step)
	);

endmodule
